// ===== sv/rps_pkg.sv =====
// Package for the routing parent selector: word types, configuration struct,
// register indexes and fixed constants. No dependencies.
package rps_pkg;

  // Fixed arithmetic constants.
  localparam logic [9:0]  SCORE_CAP     = 10'd1000;
  localparam logic [15:0] RANK_INF      = 16'hFFFF;
  // ETX divisor of 128 is applied as a right shift.
  localparam int unsigned ETX_DIV_SHIFT = 7;

  // Configuration register indexes.
  localparam logic [2:0] REG_MIN_HOP    = 3'd0;
  localparam logic [2:0] REG_MAX_INC    = 3'd1;
  localparam logic [2:0] REG_SWITCH_THR = 3'd2;
  localparam logic [2:0] REG_MAX_ETX    = 3'd3;
  localparam logic [2:0] REG_DEFAULT_ETX = 3'd4;
  localparam logic [2:0] REG_MIN_SCORE  = 3'd5;

  // Choice codes.
  localparam logic [1:0] CHOICE_NONE   = 2'd0;
  localparam logic [1:0] CHOICE_FIRST  = 2'd1;
  localparam logic [1:0] CHOICE_SECOND = 2'd2;

  // Input word: two candidate parents.
  typedef struct packed {
    logic        first_present;
    logic [15:0] first_score;
    logic [15:0] first_etx;
    logic [15:0] first_rank;
    logic        first_preferred;
    logic        second_present;
    logic [15:0] second_score;
    logic [15:0] second_etx;
    logic [15:0] second_rank;
    logic        second_preferred;
  } item_t;

  // Result word.
  typedef struct packed {
    logic [1:0]  choice;
    logic [15:0] chosen_rank;
  } result_t;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [15:0] min_hop_rank_increase;
    logic [15:0] max_rank_increase;
    logic [9:0]  switch_threshold;
    logic [15:0] max_etx;
    logic [15:0] default_etx;
    logic [9:0]  min_score;
  } cfg_t;

endpackage

// ===== sv/routing_parent_selector_unit.sv =====
// Routing parent selector top level: configuration registers, two candidate
// datapaths (rps_cand) and the selection stage. Depends on rps_pkg, rps_cand.
// A result strobes on done once its word has passed candidate stages A, B and C and the output register.
// Throughput: one word per cycle; the candidate rank pipes and the selection
// stage are fully pipelined, and the receiver cannot stall the output.
// Reset: synchronous, clears the pipeline valid bits and loads the register
// defaults; busy is high only while rst is high.
module routing_parent_selector_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  rps_pkg::item_t   item,
  output logic             done,
  output rps_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_idx,
  input  logic [15:0]      cfg_wdata
);

  rps_pkg::cfg_t cfg;

  // Valid bits and the flags that bypass the candidate pipes.
  logic [2:0] vld;
  logic [2:0] p1_d;
  logic [2:0] p2_d;
  logic [2:0] f1_d;
  logic [2:0] f2_d;

  logic [9:0]  t1;
  logic [9:0]  t2;
  logic [15:0] e1;
  logic [15:0] e2;
  logic [15:0] r1;
  logic [15:0] r2;
  logic        ok1;
  logic        ok2;

  logic [10:0] t1_thr;
  logic [10:0] t2_thr;
  logic [1:0]  pick;

  assign busy = rst;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_hop_rank_increase <= 16'd256;
      cfg.max_rank_increase     <= 16'd1792;
      cfg.switch_threshold      <= 10'd300;
      cfg.max_etx               <= 16'd1024;
      cfg.default_etx           <= 16'd256;
      cfg.min_score             <= 10'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rps_pkg::REG_MIN_HOP:     cfg.min_hop_rank_increase <= cfg_wdata;
        rps_pkg::REG_MAX_INC:     cfg.max_rank_increase     <= cfg_wdata;
        rps_pkg::REG_SWITCH_THR:  cfg.switch_threshold      <= cfg_wdata[9:0];
        rps_pkg::REG_MAX_ETX:     cfg.max_etx               <= cfg_wdata;
        rps_pkg::REG_DEFAULT_ETX: cfg.default_etx           <= cfg_wdata;
        rps_pkg::REG_MIN_SCORE:   cfg.min_score             <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // Valid shift register for the three candidate stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 3'd0;
    end else begin
      vld <= {vld[1:0], start & !busy};
    end
  end

  // Presence and preference flags follow their word through the pipe.
  always_ff @(posedge clk) begin
    p1_d <= {p1_d[1:0], item.first_present};
    p2_d <= {p2_d[1:0], item.second_present};
    f1_d <= {f1_d[1:0], item.first_preferred};
    f2_d <= {f2_d[1:0], item.second_preferred};
  end

  rps_cand u_first (
    .clk       (clk),
    .cfg       (cfg),
    .score     (item.first_score),
    .etx       (item.first_etx),
    .rank      (item.first_rank),
    .score_q   (t1),
    .etx_q     (e1),
    .rank_q    (r1),
    .link_ok_q (ok1)
  );

  rps_cand u_second (
    .clk       (clk),
    .cfg       (cfg),
    .score     (item.second_score),
    .etx       (item.second_etx),
    .rank      (item.second_rank),
    .score_q   (t2),
    .etx_q     (e2),
    .rank_q    (r2),
    .link_ok_q (ok2)
  );

  // Selection: presence, link check, infinite rank, hysteresis, then tie-breaks.
  assign t1_thr = 11'(t1) + 11'(cfg.switch_threshold);
  assign t2_thr = 11'(t2) + 11'(cfg.switch_threshold);

  always_comb begin
    if (!p1_d[2] && !p2_d[2]) begin
      pick = rps_pkg::CHOICE_NONE;
    end else if (!p1_d[2]) begin
      pick = rps_pkg::CHOICE_SECOND;
    end else if (!p2_d[2]) begin
      pick = rps_pkg::CHOICE_FIRST;
    end else if (!ok1) begin
      pick = rps_pkg::CHOICE_SECOND;
    end else if (!ok2) begin
      pick = rps_pkg::CHOICE_FIRST;
    end else if (r1 == rps_pkg::RANK_INF) begin
      pick = (r2 == rps_pkg::RANK_INF) ? rps_pkg::CHOICE_FIRST : rps_pkg::CHOICE_SECOND;
    end else if (r2 == rps_pkg::RANK_INF) begin
      pick = rps_pkg::CHOICE_FIRST;
    end else if (f1_d[2] && (11'(t2) <= t1_thr)) begin
      pick = rps_pkg::CHOICE_FIRST;
    end else if (!f1_d[2] && f2_d[2] && (11'(t1) <= t2_thr)) begin
      pick = rps_pkg::CHOICE_SECOND;
    end else if (t2 > t1) begin
      pick = rps_pkg::CHOICE_SECOND;
    end else if (t1 > t2) begin
      pick = rps_pkg::CHOICE_FIRST;
    end else if (r2 < r1) begin
      pick = rps_pkg::CHOICE_SECOND;
    end else if (r1 < r2) begin
      pick = rps_pkg::CHOICE_FIRST;
    end else begin
      pick = (e2 < e1) ? rps_pkg::CHOICE_SECOND : rps_pkg::CHOICE_FIRST;
    end
  end

  // Output register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    result.choice <= pick;
    case (pick)
      rps_pkg::CHOICE_FIRST:  result.chosen_rank <= r1;
      rps_pkg::CHOICE_SECOND: result.chosen_rank <= r2;
      default:                result.chosen_rank <= rps_pkg::RANK_INF;
    endcase
  end

endmodule

// ===== sv/rps_cand.sv =====
// Three-stage per-candidate datapath: score clamp, effective ETX, link check
// and rank through the parent. Depends on rps_pkg.
module rps_cand (
  input  logic              clk,
  input  rps_pkg::cfg_t     cfg,
  input  logic [15:0]       score,
  input  logic [15:0]       etx,
  input  logic [15:0]       rank,
  output logic [9:0]        score_q,
  output logic [15:0]       etx_q,
  output logic [15:0]       rank_q,
  output logic              link_ok_q
);

  // Stage A registers.
  logic [9:0]  a_score;
  logic [15:0] a_etx;
  logic [15:0] a_rank;
  logic        a_bad;
  logic [31:0] a_prod;

  // Stage B registers.
  logic [9:0]  b_score;
  logic [15:0] b_etx;
  logic [15:0] b_rank;
  logic        b_bad;
  logic        b_ok;
  logic [24:0] b_inc;

  logic [15:0] eff_etx;
  logic [24:0] quot;
  logic [24:0] inc_raised;
  logic [24:0] inc_next;
  logic [25:0] sum;

  // Stage A: clamp the score, substitute the default ETX and start the product.
  assign eff_etx = (etx != 16'd0) ? etx : cfg.default_etx;

  always_ff @(posedge clk) begin
    a_score <= (score > {6'd0, rps_pkg::SCORE_CAP}) ? rps_pkg::SCORE_CAP : score[9:0];
    a_etx   <= eff_etx;
    a_rank  <= rank;
    a_bad   <= (eff_etx == 16'd0) || (eff_etx == 16'hFFFF) || (eff_etx > cfg.max_etx);
    a_prod  <= 32'(cfg.min_hop_rank_increase) * 32'(eff_etx);
  end

  // Stage B: scale the product, raise to the hop minimum, apply a nonzero cap and check the link.
  assign quot       = a_prod[31:rps_pkg::ETX_DIV_SHIFT];
  assign inc_raised = (quot < 25'(cfg.min_hop_rank_increase)) ?
                      25'(cfg.min_hop_rank_increase) : quot;
  assign inc_next   = ((cfg.max_rank_increase != 16'd0) &&
                       (inc_raised > 25'(cfg.max_rank_increase))) ?
                      25'(cfg.max_rank_increase) : inc_raised;

  always_ff @(posedge clk) begin
    b_score <= a_score;
    b_etx   <= a_etx;
    b_rank  <= a_rank;
    b_bad   <= a_bad;
    b_ok    <= !a_bad && (a_score >= cfg.min_score);
    b_inc   <= inc_next;
  end

  // Stage C: add the increment and saturate to infinite rank.
  assign sum = 26'(b_rank) + 26'(b_inc);

  always_ff @(posedge clk) begin
    score_q   <= b_score;
    etx_q     <= b_etx;
    link_ok_q <= b_ok;
    if (b_bad || (b_rank == rps_pkg::RANK_INF) || (sum >= 26'(rps_pkg::RANK_INF))) begin
      rank_q <= rps_pkg::RANK_INF;
    end else begin
      rank_q <= sum[15:0];
    end
  end

endmodule

// ===== sv/rps_checker.sv =====
// Port-level checker for the routing parent selector and its bind statement.
// Depends on rps_pkg and routing_parent_selector_unit.
module rps_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input rps_pkg::result_t result
);

  // Every accepted word is followed by a result strobe on done.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted word produced no result after four cycles");

  // On done, the choice code never takes the unused value.
  a_choice: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.choice == rps_pkg::CHOICE_NONE ||
              result.choice == rps_pkg::CHOICE_FIRST ||
              result.choice == rps_pkg::CHOICE_SECOND))
    else $error("result carries an undefined choice code");

  // With no candidate chosen the rank is infinite.
  a_none_rank: assert property (@(posedge clk) disable iff (rst)
    (done && result.choice == rps_pkg::CHOICE_NONE) |->
      (result.chosen_rank == rps_pkg::RANK_INF))
    else $error("no parent chosen but rank is finite");

  // Reset flushes the pipeline.
  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

endmodule

bind routing_parent_selector_unit rps_checker u_rps_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
